### design/pool_slot_allocator_core_defines.svh
// assertion macros for the pool slot allocator core
`ifndef POOL_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define POOL_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// property checked on clk, off while rst_n is low
`define PSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked on clk at every edge, reset included
`define PSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PSA_ASSERT(lbl, prop, msg)
`define PSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/psa_pkg.sv
// types and constants of the pool slot allocator
package psa_pkg;

  localparam int NUM_BLOCKS          = 16;
  localparam int MAX_SLOTS_PER_BLOCK = 256;
  localparam int BLK_W               = 4;
  localparam int OFF_W               = 8;
  localparam int IDX_W               = BLK_W + OFF_W;
  localparam int STORE_DEPTH         = NUM_BLOCKS * MAX_SLOTS_PER_BLOCK;
  localparam int FB_W                = BLK_W + 1;
  localparam int SPB_W               = 9;
  localparam int LINK_W              = IDX_W + 1;

  localparam logic [SPB_W-1:0] SPB_RESET = SPB_W'(256);

  typedef enum logic [1:0] {
    FUNC_ALLOC    = 2'd0,
    FUNC_FREE     = 2'd1,
    FUNC_QUERY    = 2'd2,
    FUNC_FREE_ALL = 2'd3
  } psa_func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_BAD_FREE  = 2'd2
  } psa_status_t;

  typedef struct packed {
    psa_func_t        func;
    logic [BLK_W-1:0] slot_block;
    logic [OFF_W-1:0] slot_offset;
  } psa_req_t;

  typedef struct packed {
    logic [BLK_W-1:0] got_block;
    logic [OFF_W-1:0] got_offset;
    psa_status_t      status;
    logic             slot_is_free;
  } psa_rsp_t;

endpackage

### design/psa_ram.sv
// simple dual-port ram, one write and one registered read per cycle
module psa_ram
#(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 13
)
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/pool_slot_allocator_core.sv
// top level of the pool slot allocator: control, pool state and the two memories
//
// Fixed-size slot allocator. A request (start high while busy is low) is one of
// allocate, free, query or free-all. Allocate pops the most recently freed slot
// from a LIFO free list, otherwise hands out the next fresh slot; free pushes a
// handed-out slot after checking it; query reports whether a slot is on the list.
// Every request gives exactly one result: out_valid is high for one cycle with
// out_rsp, starting one cycle after the request edge, and cannot be held off, so
// the receiver must take it in that cycle. Allocate, free and query each read the
// link and mark memories first (registered read), then update the pool and write
// back; the link read at the list head is what sets the pace of back-to-back
// pops. Free-all sweeps the 4096-entry mark memory one entry a cycle; after reset
// the same sweep runs before the first request is taken. Configuration writes
// on cfg_valid/cfg_data are always taken (cfg_ready is tied high) and must only
// happen while the block is idle.
`include "pool_slot_allocator_core_defines.svh"

module pool_slot_allocator_core
  import psa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             start,
  output logic             busy,
  input  psa_req_t         in_req,
  // result channel
  output logic             out_valid,
  output psa_rsp_t         out_rsp,
  // slots_per_block register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SPB_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_t;

  state_t state_r, state_nxt;

  // pool state
  logic [SPB_W-1:0] spb_r, spb_nxt;
  logic [IDX_W-1:0] free_head_r, free_head_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic [FB_W-1:0]  fresh_block_r, fresh_block_nxt;
  logic [OFF_W-1:0] fresh_offset_r, fresh_offset_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // latched request and registered result
  psa_req_t req_r, req_nxt;
  psa_rsp_t out_rsp_r, out_rsp_nxt;
  logic     out_valid_r, out_valid_nxt;

  // memory ports: link entry is {next valid, next index}
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic [LINK_W-1:0] link_rdata;
  logic              mark_we;
  logic [IDX_W-1:0]  mark_waddr;
  logic [0:0]        mark_wdata;
  logic [0:0]        mark_rdata;
  logic [IDX_W-1:0]  mark_raddr;

  // decoded request and fresh-slot arithmetic
  logic [SPB_W-1:0] eff_size;
  logic [IDX_W-1:0] req_idx;
  logic             in_range;
  logic             handed_out;
  logic [FB_W-1:0]  fb_cur;
  logic [OFF_W-1:0] fo_cur;
  logic [SPB_W-1:0] fo_inc;
  logic [FB_W-1:0]  fb_after;
  logic [OFF_W-1:0] fo_after;
  logic             exhausted;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  psa_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (free_head_r),
    .rdata (link_rdata)
  );

  psa_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (1)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  // mark read is issued in the request cycle, data arrives in exec
  assign mark_raddr = {in_req.slot_block, in_req.slot_offset};

  // effective block size: zero acts as one, clamp to the maximum
  always_comb begin
    if (spb_r == '0) begin
      eff_size = SPB_W'(1);
    end else if (spb_r > SPB_W'(MAX_SLOTS_PER_BLOCK)) begin
      eff_size = SPB_W'(MAX_SLOTS_PER_BLOCK);
    end else begin
      eff_size = spb_r;
    end
  end

  // slot index is block * max slots + offset, max slots a power of two
  assign req_idx  = {req_r.slot_block, req_r.slot_offset};
  assign in_range = ({1'b0, req_r.slot_block} < FB_W'(NUM_BLOCKS)) &&
                    ({1'b0, req_r.slot_offset} < eff_size);
  assign handed_out = ({1'b0, req_r.slot_block} < fresh_block_r) ||
                      (({1'b0, req_r.slot_block} == fresh_block_r) &&
                       (req_r.slot_offset < fresh_offset_r));

  // next fresh slot; a lowered block size first skips to the next block
  always_comb begin
    if ((fresh_block_r < FB_W'(NUM_BLOCKS)) && ({1'b0, fresh_offset_r} >= eff_size)) begin
      fb_cur = fresh_block_r + FB_W'(1);
      fo_cur = '0;
    end else begin
      fb_cur = fresh_block_r;
      fo_cur = fresh_offset_r;
    end
    exhausted = (fb_cur >= FB_W'(NUM_BLOCKS));
    fo_inc    = {1'b0, fo_cur} + SPB_W'(1);
    if (fo_inc >= eff_size) begin
      fo_after = '0;
      fb_after = fb_cur + FB_W'(1);
    end else begin
      fo_after = fo_inc[OFF_W-1:0];
      fb_after = fb_cur;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    spb_nxt          = spb_r;
    free_head_nxt    = free_head_r;
    nonempty_nxt     = nonempty_r;
    fresh_block_nxt  = fresh_block_r;
    fresh_offset_nxt = fresh_offset_r;
    clr_cnt_nxt      = clr_cnt_r;
    req_nxt          = req_r;
    out_rsp_nxt      = out_rsp_r;
    out_valid_nxt    = 1'b0;
    link_we          = 1'b0;
    link_waddr       = req_idx;
    link_wdata       = {nonempty_r, free_head_r};
    mark_we          = 1'b0;
    mark_waddr       = req_idx;
    mark_wdata       = 1'b0;

    if (cfg_valid && cfg_ready) begin
      spb_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        out_valid_nxt            = 1'b1;
        out_rsp_nxt.got_block    = '0;
        out_rsp_nxt.got_offset   = '0;
        out_rsp_nxt.status       = STAT_OK;
        out_rsp_nxt.slot_is_free = 1'b0;
        state_nxt                = ST_IDLE;
        case (req_r.func)
          FUNC_ALLOC: begin
            if (nonempty_r) begin
              // pop the list head, link data read at the head last cycle
              out_rsp_nxt.got_block  = free_head_r[IDX_W-1:OFF_W];
              out_rsp_nxt.got_offset = free_head_r[OFF_W-1:0];
              mark_we       = 1'b1;
              mark_waddr    = free_head_r;
              mark_wdata    = 1'b0;
              free_head_nxt = link_rdata[IDX_W-1:0];
              nonempty_nxt  = link_rdata[IDX_W];
            end else if (exhausted) begin
              // a pending skip to the next block still takes effect
              out_rsp_nxt.status = STAT_EXHAUSTED;
              fresh_block_nxt    = fb_cur;
              fresh_offset_nxt   = fo_cur;
            end else begin
              out_rsp_nxt.got_block  = fb_cur[BLK_W-1:0];
              out_rsp_nxt.got_offset = fo_cur;
              fresh_block_nxt  = fb_after;
              fresh_offset_nxt = fo_after;
            end
          end
          FUNC_FREE: begin
            if (!in_range || !handed_out || mark_rdata[0]) begin
              out_rsp_nxt.status = STAT_BAD_FREE;
            end else begin
              // push: link to old head, mark on list
              link_we       = 1'b1;
              mark_we       = 1'b1;
              mark_wdata    = 1'b1;
              free_head_nxt = req_idx;
              nonempty_nxt  = 1'b1;
            end
          end
          FUNC_QUERY: begin
            out_rsp_nxt.slot_is_free = in_range & mark_rdata[0];
          end
          FUNC_FREE_ALL: begin
            free_head_nxt    = '0;
            nonempty_nxt     = 1'b0;
            fresh_block_nxt  = '0;
            fresh_offset_nxt = '0;
            clr_cnt_nxt      = '0;
            state_nxt        = ST_CLEAR;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_CLEAR: begin
        // sweep the mark memory, one entry per cycle
        mark_we     = 1'b1;
        mark_waddr  = clr_cnt_r;
        mark_wdata  = 1'b0;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      spb_r          <= SPB_RESET;
      free_head_r    <= '0;
      nonempty_r     <= 1'b0;
      fresh_block_r  <= '0;
      fresh_offset_r <= '0;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      spb_r          <= spb_nxt;
      free_head_r    <= free_head_nxt;
      nonempty_r     <= nonempty_nxt;
      fresh_block_r  <= fresh_block_nxt;
      fresh_offset_r <= fresh_offset_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
      req_r          <= req_nxt;
      out_rsp_r      <= out_rsp_nxt;
    end
  end

  // a result only ever follows an exec cycle
  `PSA_ASSERT(a_result_after_exec, out_valid |-> $past(state_r == ST_EXEC), "result without exec")
  // an accepted request goes straight to exec
  `PSA_ASSERT(a_accept_to_exec,
              (start && !busy) |=> (state_r == ST_EXEC),
              "request not executed")
  // free-all always starts the mark sweep
  `PSA_ASSERT(a_free_all_clears,
              (state_r == ST_EXEC && req_r.func == FUNC_FREE_ALL) |=> (state_r == ST_CLEAR),
              "free-all without sweep")
  // exhaustion reports no slot
  `PSA_ASSERT(a_exhausted_zero,
              (out_valid && out_rsp.status == STAT_EXHAUSTED) |->
                (out_rsp.got_block == '0 && out_rsp.got_offset == '0),
              "exhausted with slot")
  // fresh block never goes beyond one past the last block
  `PSA_ASSERT_ALWAYS(a_fresh_bound,
                     !rst_n || (fresh_block_r <= FB_W'(NUM_BLOCKS)),
                     "fresh block out of range")

endmodule

### tb/pool_slot_allocator_core_tb.sv
// self-checking testbench for the pool slot allocator core
`timescale 1ns / 1ps

module pool_slot_allocator_core_tb;
  import psa_pkg::*;

  // clock, reset and the ports of the block
  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  psa_req_t         in_req;
  logic             out_valid;
  psa_rsp_t         out_rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [SPB_W-1:0] cfg_data;

  always #4 clk = ~clk;

  pool_slot_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the pool, updated when a request is accepted
  int unsigned      slots_cfg;
  bit               mark_q    [STORE_DEPTH];
  bit [IDX_W-1:0]   link_q    [STORE_DEPTH];
  bit               link_ok_q [STORE_DEPTH];
  bit [IDX_W-1:0]   head_q;
  bit               list_nonempty_q;
  int unsigned      fresh_blk_q;
  int unsigned      fresh_off_q;

  // slots handed out and not yet returned, used to build legal frees
  int unsigned      live_slots [$];

  // results still owed by the block, oldest first
  psa_rsp_t         pending_rsp [$];

  // run statistics and error bookkeeping
  int unsigned      errors;
  int unsigned      shown;
  int unsigned      useful_items;
  int unsigned      n_alloc;
  int unsigned      n_exhausted;
  int unsigned      n_freed;
  int unsigned      n_bad_free;
  int unsigned      n_query_hit;
  int unsigned      n_clear;
  bit               burst_mode;

  // register value as the block applies it: 0 acts as 1, above the max clamps
  function automatic int unsigned eff_slots();
    if (slots_cfg == 0) return 1;
    if (slots_cfg > MAX_SLOTS_PER_BLOCK) return MAX_SLOTS_PER_BLOCK;
    return slots_cfg;
  endfunction

  // empty list, no free marks, fresh position back at block 0 offset 0
  // link memory is left alone, a push always rewrites it before a pop
  function automatic void clear_pool();
    head_q          = '0;
    list_nonempty_q = 1'b0;
    foreach (mark_q[i]) mark_q[i] = 1'b0;
    fresh_blk_q     = 0;
    fresh_off_q     = 0;
    live_slots.delete();
  endfunction

  // expected result of one request, applied to the shadow pool
  function automatic psa_rsp_t predict_pool_response(psa_req_t req);
    psa_rsp_t    rsp;
    int unsigned blk;
    int unsigned off;
    int unsigned idx;
    rsp        = '0;
    rsp.status = STAT_OK;
    blk        = req.slot_block;
    off        = req.slot_offset;
    idx        = blk * MAX_SLOTS_PER_BLOCK + off;
    case (req.func)
      FUNC_ALLOC: begin
        if (list_nonempty_q) begin
          // lifo pop: most recently freed slot comes back first
          idx             = head_q;
          rsp.got_block   = BLK_W'(idx / MAX_SLOTS_PER_BLOCK);
          rsp.got_offset  = OFF_W'(idx % MAX_SLOTS_PER_BLOCK);
          mark_q[idx]     = 1'b0;
          head_q          = link_q[idx];
          list_nonempty_q = link_ok_q[idx];
          live_slots.push_back(idx);
          n_alloc++;
        end else begin
          // size lowered under the fresh position: skip to the next block
          if (fresh_blk_q < NUM_BLOCKS && fresh_off_q >= eff_slots()) begin
            fresh_blk_q++;
            fresh_off_q = 0;
          end
          if (fresh_blk_q >= NUM_BLOCKS) begin
            rsp.status = STAT_EXHAUSTED;
            n_exhausted++;
          end else begin
            rsp.got_block  = BLK_W'(fresh_blk_q);
            rsp.got_offset = OFF_W'(fresh_off_q);
            live_slots.push_back(fresh_blk_q * MAX_SLOTS_PER_BLOCK + fresh_off_q);
            fresh_off_q++;
            if (fresh_off_q >= eff_slots()) begin
              fresh_off_q = 0;
              fresh_blk_q++;
            end
            n_alloc++;
          end
        end
      end
      FUNC_FREE: begin
        // out of range, never handed out, or already on the list
        if (blk >= NUM_BLOCKS || off >= eff_slots() ||
            !(blk < fresh_blk_q || (blk == fresh_blk_q && off < fresh_off_q)) ||
            mark_q[idx]) begin
          rsp.status = STAT_BAD_FREE;
          n_bad_free++;
        end else begin
          link_q[idx]     = head_q;
          link_ok_q[idx]  = list_nonempty_q;
          mark_q[idx]     = 1'b1;
          head_q          = IDX_W'(idx);
          list_nonempty_q = 1'b1;
          for (int i = 0; i < live_slots.size(); i++) begin
            if (live_slots[i] == idx) begin
              live_slots.delete(i);
              break;
            end
          end
          n_freed++;
        end
      end
      FUNC_QUERY: begin
        // out-of-range slots read as not free, status stays ok
        if (blk < NUM_BLOCKS && off < eff_slots()) rsp.slot_is_free = mark_q[idx];
        if (rsp.slot_is_free) n_query_hit++;
      end
      default: begin
        clear_pool();
        n_clear++;
      end
    endcase
    return rsp;
  endfunction

  // one request: optional gap, then start held until the block takes it
  task automatic issue_request(psa_req_t req);
    int unsigned gap;
    psa_rsp_t    rsp;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start  = 1'b1;
    in_req = req;
    do @(posedge clk); while (busy);
    rsp = predict_pool_response(req);
    pending_rsp.push_back(rsp);
    if (rsp.status != STAT_BAD_FREE) useful_items++;
  endtask

  task automatic send_op(psa_func_t func, int unsigned blk, int unsigned off);
    psa_req_t req;
    req.func        = func;
    req.slot_block  = BLK_W'(blk);
    req.slot_offset = OFF_W'(off);
    issue_request(req);
  endtask

  // stop sending, let every owed result arrive and any clearing sweep finish
  task automatic wait_pool_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
  endtask

  // register write, only called while the pool is idle
  task automatic write_slots_per_block(logic [SPB_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    slots_cfg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly legal traffic against live slots, some double and stray frees
  function automatic psa_req_t pick_request();
    psa_req_t    req;
    int unsigned roll;
    int unsigned idx;
    req.func        = FUNC_ALLOC;
    req.slot_block  = BLK_W'($urandom);
    req.slot_offset = OFF_W'($urandom);
    roll            = $urandom_range(0, 199);
    idx             = STORE_DEPTH;
    if (roll < 80) begin
      req.func = FUNC_ALLOC;
    end else if (roll < 140) begin
      req.func = FUNC_FREE;
      if (roll < 128 && live_slots.size() != 0)
        idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
      else if (roll < 134 && list_nonempty_q)
        idx = head_q;
    end else if (roll < 198) begin
      req.func = FUNC_QUERY;
      if (roll < 160 && live_slots.size() != 0)
        idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
      else if (roll < 180 && list_nonempty_q)
        idx = head_q;
    end else begin
      req.func = FUNC_FREE_ALL;
    end
    if (idx < STORE_DEPTH) begin
      req.slot_block  = BLK_W'(idx / MAX_SLOTS_PER_BLOCK);
      req.slot_offset = OFF_W'(idx % MAX_SLOTS_PER_BLOCK);
    end
    return req;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    errors++;
    if (shown < 40) begin
      shown++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // every strobed result is checked against the oldest expectation
  always @(posedge clk) begin : check_results
    psa_rsp_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        if (shown < 40) begin
          shown++;
          $display("%0t: result with no request pending, expected none, actual %p",
                   $time, out_rsp);
        end
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.got_block !== want.got_block)
          report_field("got_block", want.got_block, out_rsp.got_block);
        if (out_rsp.got_offset !== want.got_offset)
          report_field("got_offset", want.got_offset, out_rsp.got_offset);
        if (out_rsp.status !== want.status)
          report_field("status", want.status, out_rsp.status);
        if (out_rsp.slot_is_free !== want.slot_is_free)
          report_field("slot_is_free", want.slot_is_free, out_rsp.slot_is_free);
      end
    end
  end

  // reset defaults, lifo reuse, double free, stray frees, query of the head
  task automatic test_lifo_and_bad_frees();
    send_op(FUNC_QUERY, 15, 255);   // nothing handed out yet
    send_op(FUNC_FREE, 0, 0);       // free before any allocation
    send_op(FUNC_ALLOC, 0, 0);
    send_op(FUNC_ALLOC, 0, 0);
    send_op(FUNC_FREE, 0, 1);
    send_op(FUNC_FREE, 0, 1);       // already on the list
    send_op(FUNC_QUERY, 0, 1);      // list head must read as free
    send_op(FUNC_FREE, 0, 0);
    send_op(FUNC_QUERY, 0, 1);      // now second entry of the list
    send_op(FUNC_ALLOC, 0, 0);      // pops the slot freed last
    send_op(FUNC_ALLOC, 0, 0);
    send_op(FUNC_ALLOC, 0, 0);      // list empty again, fresh slot
    send_op(FUNC_FREE, 0, 255);     // in range but never handed out
    send_op(FUNC_FREE, 15, 0);
  endtask

  // clamped register, size lowered under the fresh position, free-all
  task automatic test_register_extremes();
    wait_pool_idle();
    write_slots_per_block(SPB_W'(511));  // acts as the maximum
    send_op(FUNC_ALLOC, 0, 0);
    wait_pool_idle();
    write_slots_per_block(SPB_W'(2));    // fresh offset now past the end
    send_op(FUNC_ALLOC, 0, 0);           // jumps to the next block
    send_op(FUNC_FREE, 0, 3);            // offset beyond the new size
    send_op(FUNC_QUERY, 0, 3);
    send_op(FUNC_FREE, 1, 1);            // not handed out yet
    send_op(FUNC_FREE_ALL, 0, 0);
    send_op(FUNC_QUERY, 0, 0);
  endtask

  // size 0 acts as one slot per block: run the pool dry and recover
  task automatic test_exhaustion();
    wait_pool_idle();
    write_slots_per_block(SPB_W'(0));
    send_op(FUNC_FREE_ALL, 0, 0);
    repeat (NUM_BLOCKS) send_op(FUNC_ALLOC, 0, 0);
    send_op(FUNC_ALLOC, 0, 0);           // no block left
    send_op(FUNC_ALLOC, 15, 255);
    send_op(FUNC_FREE, 15, 0);
    send_op(FUNC_ALLOC, 0, 0);           // reused from the list
  endtask

  task automatic run_traffic_phase(int unsigned spb, bit clear_first, int unsigned n);
    int unsigned stop_at;
    wait_pool_idle();
    write_slots_per_block(SPB_W'(spb));
    if (clear_first) send_op(FUNC_FREE_ALL, 0, 0);
    stop_at = useful_items + n;
    while (useful_items < stop_at) begin
      // bursts with no gaps alternate with random gaps
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      // now and then hold off until the block has answered everything
      if ($urandom_range(0, 149) == 0) wait_pool_idle();
      issue_request(pick_request());
    end
    burst_mode = 1'b0;
  endtask

  // phases without a clear keep the pool across a size change
  task automatic test_random_traffic();
    run_traffic_phase(256, 1'b1, 104);
    run_traffic_phase(1, 1'b1, 104);
    run_traffic_phase(2, 1'b0, 104);
    run_traffic_phase(5, 1'b1, 104);
    run_traffic_phase(0, 1'b0, 104);
    run_traffic_phase(17, 1'b1, 104);
    run_traffic_phase(3, 1'b0, 104);
    run_traffic_phase(511, 1'b1, 104);
    run_traffic_phase(64, 1'b0, 104);
    run_traffic_phase(255, 1'b1, 104);
    run_traffic_phase($urandom_range(1, 300), 1'b0, 104);
  endtask

  initial begin
    start      = 1'b0;
    in_req     = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    errors     = 0;
    shown      = 0;
    burst_mode = 1'b0;
    slots_cfg  = SPB_RESET;
    clear_pool();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_lifo_and_bad_frees();
    test_register_extremes();
    test_exhaustion();
    test_random_traffic();

    // let the last results and any clearing sweep finish, watch for strays
    wait_pool_idle();
    repeat (16) @(posedge clk);

    $display("%0d requests: %0d allocations, %0d exhausted, %0d frees, %0d rejected frees",
             useful_items + n_bad_free, n_alloc, n_exhausted, n_freed, n_bad_free);
    $display("%0d queries hit a free slot, %0d pool clears, sizes 0 to 511 applied",
             n_query_hit, n_clear);
    if (errors == 0) begin
      $display("[pool_slot_allocator_core] OK");
    end else begin
      $display("[pool_slot_allocator_core] ERROR");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(20_000_000);
    $display("timeout at %0t with %0d results outstanding", $time, pending_rsp.size());
    $display("[pool_slot_allocator_core] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/psa_pkg.sv
design/psa_ram.sv
design/pool_slot_allocator_core.sv
tb/pool_slot_allocator_core_tb.sv
